### rtl/jilq_pkg.sv
// Package for the just-intonation lattice quantizer.
// Holds the state encoding, the lattice limits and the prime log constants.
// No dependencies.
`default_nettype none
package jilq_pkg;
  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned NumPrimes = 8;
  localparam int unsigned LimW = 5;
  localparam int unsigned LogW = 23;
  localparam int unsigned ValW = 36;
  localparam int unsigned CntW = $clog2(MaxPoints + 2);
  localparam int unsigned IdxW = 4;

  // log2 of 2, 3, 5, 7, 11, 13, 17 and 19 with 20 fraction bits.
  localparam logic [LogW-1:0] LogC [NumPrimes] = '{
    23'd1048576, 23'd1661954, 23'd2434718, 23'd2943725,
    23'd3627477, 23'd3880192, 23'd4286015, 23'd4454275
  };

  localparam logic [LimW-1:0] LimitReset [NumPrimes] = '{
    5'd10, 5'd2, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CNT, ST_WR, ST_RD, ST_SEARCH, ST_OUT
  } state_e;
endpackage
`default_nettype wire

### rtl/jilq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module jilq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/just_intonation_lattice_quantizer_unit.sv
// Top level of the just-intonation lattice quantizer.
// Depends on jilq_pkg and jilq_ram.
//
// After reset the block loads the default limits into its limit memory and
// takes no word then. Each word then passes through a check of the configured
// point count, a copy of the limits when they fit, a read-back of the active
// limits, a search that visits one lattice point per cycle (the product of
// 2*limit+1, at most 4096), which a first-channel word skips, and the
// hand-over of the result; no new word is taken until it is handed over.
`default_nettype none
module just_intonation_lattice_quantizer_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [jilq_pkg::IdxW-1:0]    cfg_index_i,
  input  wire logic [jilq_pkg::LimW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [31:0]           reference_pitch_i,
  input  wire logic signed [31:0]           channel_pitch_i,
  input  wire logic                         is_first_channel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [31:0]                tuned_pitch_o,
  output logic [19:0]                       interval_fraction_o,
  output logic                              lattice_overflow_o
);
  localparam int unsigned NP = jilq_pkg::NumPrimes;
  localparam int unsigned VW = jilq_pkg::ValW;
  localparam int unsigned CW = jilq_pkg::CntW;
  localparam int unsigned LW = jilq_pkg::LimW;
  localparam int unsigned AW = $clog2(NP);
  localparam logic [jilq_pkg::IdxW-1:0] IdxLimit = jilq_pkg::IdxW'(NP);

  jilq_pkg::state_e state_q, state_d;
  logic [AW:0]            k_q, k_d;
  logic [LW-1:0]          cfg_q [NP];
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic signed [31:0]     ref_q, ref_d;
  logic signed [VW-1:0]   tgt_q, tgt_d;
  logic                   first_q, first_d;
  logic [LW-1:0]          lim_q [NP];
  logic [LW-1:0]          lim_d [NP];
  logic signed [VW-1:0]   delta_q [NP];
  logic signed [VW-1:0]   delta_d [NP];
  logic signed [VW-1:0]   pacc_q, pacc_d;
  logic [CW-1:0]          acnt_q, acnt_d;
  logic [LW:0]            u_q [NP];
  logic [LW:0]            u_d [NP];
  logic signed [VW-1:0]   v_q, v_d;
  logic signed [VW-1:0]   best_q, best_d;
  logic [VW-1:0]          bestd_q, bestd_d;
  logic [CW-1:0]          it_q, it_d;
  logic                   out_valid_q;
  logic signed [31:0]     tuned_q;
  logic [19:0]            frac_q;
  logic                   ovf_out_q;
  logic                   out_load;
  logic signed [31:0]     tuned_c;
  logic [19:0]            frac_c;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [LW-1:0]          ram_wdata, ram_rdata;

  jilq_ram #(.Width(LW), .Depth(NP)) u_lim_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        cfg_q[i] <= jilq_pkg::LimitReset[i];
      end
    end else if (cfg_valid_i && cfg_index_i < IdxLimit) begin
      cfg_q[cfg_index_i[AW-1:0]] <= cfg_data_i;
    end
  end

  logic [CW+LW:0]         cmul;
  logic [LW+jilq_pkg::LogW-1:0] prod;
  logic [CW+LW:0]         amul;
  logic signed [VW-1:0]   dv;
  logic [VW-1:0]          dabs;
  logic                   carry;
  logic [AW-1:0]          sel;
  logic signed [VW-1:0]   sum_c;
  logic [AW-1:0]          j;

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    ref_d = ref_q;
    tgt_d = tgt_q;
    first_d = first_q;
    lim_d = lim_q;
    delta_d = delta_q;
    pacc_d = pacc_q;
    acnt_d = acnt_q;
    u_d = u_q;
    v_d = v_q;
    best_d = best_q;
    bestd_d = bestd_q;
    it_d = it_q;
    in_stall_o = 1'b1;
    out_load = 1'b0;
    ram_we = 1'b0;
    ram_waddr = k_q[AW-1:0];
    ram_wdata = cfg_q[k_q[AW-1:0]];
    ram_raddr = k_q[AW-1:0];
    j = AW'(k_q - 1'b1);
    cmul = cnt_q * ({cfg_q[k_q[AW-1:0]], 1'b1});
    prod = ram_rdata * jilq_pkg::LogC[j];
    amul = acnt_q * ({ram_rdata, 1'b1});
    dv = v_q - tgt_q;
    dabs = dv[VW-1] ? VW'(-dv) : VW'(dv);
    carry = 1'b1;
    sel = '0;
    for (int i = 0; i < NP; i++) begin
      if (carry) begin
        if (u_q[i] < {lim_q[i], 1'b0}) begin
          u_d[i] = u_q[i] + 1'b1;
          carry = 1'b0;
          sel = AW'(i);
        end else begin
          u_d[i] = '0;
        end
      end
    end
    case (state_q)
      jilq_pkg::ST_INIT: begin
        ram_we = 1'b1;
        ram_wdata = jilq_pkg::LimitReset[k_q[AW-1:0]];
        k_d = k_q + 1'b1;
        if (k_q == (AW+1)'(NP - 1)) begin
          k_d = '0;
          state_d = jilq_pkg::ST_IDLE;
        end
      end
      jilq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ref_d = reference_pitch_i;
          tgt_d = VW'(channel_pitch_i) - VW'(reference_pitch_i);
          first_d = is_first_channel_i;
          cnt_d = CW'(1);
          acnt_d = CW'(1);
          pacc_d = '0;
          k_d = '0;
          state_d = jilq_pkg::ST_CNT;
        end
      end
      jilq_pkg::ST_CNT: begin
        cnt_d = (cmul > (CW+LW+1)'(jilq_pkg::MaxPoints)) ?
                CW'(jilq_pkg::MaxPoints + 1) : CW'(cmul);
        k_d = k_q + 1'b1;
        if (k_q == (AW+1)'(NP - 1)) begin
          k_d = '0;
          ovf_d = (cnt_d > CW'(jilq_pkg::MaxPoints));
          state_d = ovf_d ? jilq_pkg::ST_RD : jilq_pkg::ST_WR;
        end
      end
      jilq_pkg::ST_WR: begin
        ram_we = 1'b1;
        k_d = k_q + 1'b1;
        if (k_q == (AW+1)'(NP - 1)) begin
          k_d = '0;
          state_d = jilq_pkg::ST_RD;
        end
      end
      jilq_pkg::ST_RD: begin
        k_d = k_q + 1'b1;
        if (k_q != '0) begin
          lim_d[j] = ram_rdata;
          delta_d[j] = VW'(jilq_pkg::LogC[j]) - pacc_q;
          pacc_d = pacc_q + VW'({prod, 1'b0});
          acnt_d = CW'(amul);
        end
        if (k_q == (AW+1)'(NP)) begin
          v_d = -(pacc_d >>> 1);
          it_d = '0;
          for (int i = 0; i < NP; i++) begin
            u_d[i] = '0;
          end
          state_d = first_q ? jilq_pkg::ST_OUT : jilq_pkg::ST_SEARCH;
        end
      end
      jilq_pkg::ST_SEARCH: begin
        if (it_q == '0 || dabs < bestd_q || (dabs == bestd_q && v_q > best_q)) begin
          best_d = v_q;
          bestd_d = dabs;
        end
        v_d = v_q + delta_q[sel];
        it_d = it_q + 1'b1;
        if (it_q == acnt_q - 1'b1) begin
          state_d = jilq_pkg::ST_OUT;
        end
      end
      jilq_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = jilq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jilq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sum_c = VW'(ref_q) + best_q;
    if (sum_c > VW'(33'sh0_7FFF_FFFF)) begin
      tuned_c = 32'sh7FFF_FFFF;
    end else if (sum_c < -VW'(33'sh0_8000_0000)) begin
      tuned_c = 32'sh8000_0000;
    end else begin
      tuned_c = sum_c[31:0];
    end
    frac_c = best_q[19:0];
    if (first_q) begin
      tuned_c = ref_q;
      frac_c = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jilq_pkg::ST_INIT;
      k_q <= '0;
      out_valid_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      ovf_q <= ovf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    ref_q <= ref_d;
    tgt_q <= tgt_d;
    first_q <= first_d;
    lim_q <= lim_d;
    delta_q <= delta_d;
    pacc_q <= pacc_d;
    acnt_q <= acnt_d;
    u_q <= u_d;
    v_q <= v_d;
    best_q <= best_d;
    bestd_q <= bestd_d;
    it_q <= it_d;
    if (out_load) begin
      tuned_q <= tuned_c;
      frac_q <= frac_c;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tuned_pitch_o = tuned_q;
  assign interval_fraction_o = frac_q;
  assign lattice_overflow_o = ovf_out_q;

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jilq_pkg::ST_SEARCH |-> it_q < acnt_q)
    else $error("search ran past the point count");
  a_no_write_on_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jilq_pkg::ST_WR |-> !ovf_q)
    else $error("limits written despite overflow");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == jilq_pkg::ST_CNT)
    else $error("accepted word did not start the count check");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("result overwrote a waiting word");
endmodule
`default_nettype wire

### verif/tb_just_intonation_lattice_quantizer_unit.sv
// Self-checking testbench for just_intonation_lattice_quantizer_unit.
// Predicts every tuned pitch word with a scoreboard class and checks each one.
// Depends on jilq_pkg and the RTL of the quantizer.
module tb_just_intonation_lattice_quantizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumLimits = 8;
  localparam logic [jilq_pkg::IdxW-1:0] IdxUnused = 4'd15;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic signed [31:0] pitch;
    logic [19:0]        frac;
    logic               ovf;
  } tuned_word_t;

  class lattice_scoreboard;
    logic [4:0]  cfg_lim [NumLimits];
    logic [4:0]  act_lim [NumLimits];
    longint      log_q20 [NumLimits];
    tuned_word_t pending [$];
    int          errors;
    int          checked;
    int          overflows;

    function new();
      log_q20 = '{1048576, 1661954, 2434718, 2943725,
                  3627477, 3880192, 4286015, 4454275};
      cfg_lim = '{5'd10, 5'd2, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
      act_lim = cfg_lim;
      errors = 0;
      checked = 0;
      overflows = 0;
    endfunction

    function void set_limit(int idx, logic [4:0] val);
      if (idx < NumLimits) begin
        cfg_lim[idx] = val;
      end
    endfunction

    function longint nearest_interval(longint target);
      longint e [NumLimits];
      longint v, best, best_dist, span, lim;
      longint unsigned cnt, i;
      int k;
      v = 0;
      best = 0;
      best_dist = -1;
      cnt = 1;
      for (k = 0; k < NumLimits; k++) begin
        lim = longint'(act_lim[k]);
        e[k] = -lim;
        v -= lim * log_q20[k];
        cnt *= 2 * lim + 1;
      end
      for (i = 0; i < cnt; i++) begin
        span = (v > target) ? v - target : target - v;
        if (best_dist < 0 || span < best_dist || (span == best_dist && v > best)) begin
          best_dist = span;
          best = v;
        end
        for (k = 0; k < NumLimits; k++) begin
          lim = longint'(act_lim[k]);
          if (e[k] < lim) begin
            e[k]++;
            v += log_q20[k];
            break;
          end
          v -= 2 * lim * log_q20[k];
          e[k] = -lim;
        end
      end
      return best;
    endfunction

    function void note_word(logic signed [31:0] ref_p, logic signed [31:0] ch_p,
                            logic first);
      longint unsigned cnt;
      longint point, sum;
      logic [63:0] point_bits;
      tuned_word_t w;
      int k;
      cnt = 1;
      for (k = 0; k < NumLimits; k++) begin
        cnt *= 2 * longint'(cfg_lim[k]) + 1;
      end
      w.ovf = (cnt > jilq_pkg::MaxPoints);
      if (!w.ovf) begin
        act_lim = cfg_lim;
      end else begin
        overflows++;
      end
      w.pitch = ref_p;
      w.frac = '0;
      if (!first) begin
        point = nearest_interval(longint'(ch_p) - longint'(ref_p));
        point_bits = point;
        w.frac = point_bits[19:0];
        sum = longint'(ref_p) + point;
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647;
        end else if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648;
        end
        w.pitch = sum[31:0];
      end
      pending.push_back(w);
    endfunction

    function void check_word(logic signed [31:0] pitch, logic [19:0] frac, logic ovf);
      tuned_word_t w;
      if (pending.size() == 0) begin
        $error("tuned word with no expectation waiting");
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (pitch !== w.pitch) begin
        $error("tuned_pitch expected %0d got %0d", w.pitch, pitch);
        errors++;
      end
      if (frac !== w.frac) begin
        $error("interval_fraction expected %0d got %0d", w.frac, frac);
        errors++;
      end
      if (ovf !== w.ovf) begin
        $error("lattice_overflow expected %0b got %0b", w.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [jilq_pkg::IdxW-1:0] cfg_index_i = '0;
  logic [jilq_pkg::LimW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] reference_pitch_i = '0;
  logic signed [31:0] channel_pitch_i = '0;
  logic is_first_channel_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] tuned_pitch_o;
  logic [19:0] interval_fraction_o;
  logic lattice_overflow_o;

  lattice_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;

  just_intonation_lattice_quantizer_unit dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(tuned_pitch_o, interval_fraction_o, lattice_overflow_o);
    end
    if ($urandom_range(0, 99) < 3) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 40);
      default: out_stall_i <= ($urandom_range(0, 99) < 90);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("tb_just_intonation_lattice_quantizer_unit failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_limit(logic [jilq_pkg::IdxW-1:0] idx, logic [jilq_pkg::LimW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    sb.set_limit(idx, val);
  endtask

  task automatic set_lattice(logic [jilq_pkg::LimW-1:0] lims [NumLimits], bit poke_unused);
    in_valid_i <= 1'b0;
    wait_drained();
    for (int k = 0; k < NumLimits; k++) begin
      write_limit(k[jilq_pkg::IdxW-1:0], lims[k]);
    end
    if (poke_unused) begin
      write_limit(IdxUnused, 5'd31);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_word(logic signed [31:0] ref_p, logic signed [31:0] ch_p,
                           logic first);
    int gap;
    in_valid_i <= 1'b1;
    reference_pitch_i <= ref_p;
    channel_pitch_i <= ch_p;
    is_first_channel_i <= first;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_word(ref_p, ch_p, first);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int n);
    logic signed [31:0] ref_p, ch_p;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      ref_p = $urandom();
      ch_p = $urandom();
      if (r >= 45) begin
        ch_p = ref_p + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      end
      send_word(ref_p, ch_p, r < 10);
    end
  endtask

  initial begin
    logic [jilq_pkg::LimW-1:0] lims [NumLimits];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_word(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_word(32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_word(32'sh1234_5678, 32'sh1234_5678, 1'b0);
    send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh7FF0_0000, 32'sh8000_0000, 1'b0);
    send_word(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_word(32'shFFFF_FFFF, 32'sh0000_0001, 1'b0);
    send_random(10);

    lims = '{5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
    set_lattice(lims, 1'b1);
    send_word(32'sh0000_0000, 32'sh0008_0000, 1'b0);
    send_word(32'sh0000_0000, -32'sh0008_0000, 1'b0);
    send_word(32'sh0010_0000, 32'sh0018_0000, 1'b0);
    send_random(8);

    lims = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
    set_lattice(lims, 1'b0);
    send_random(8);

    lims = '{5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20};
    set_lattice(lims, 1'b0);
    send_random(8);

    lims = '{5'd31, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
    set_lattice(lims, 1'b0);
    send_random(6);

    lims = '{5'd2, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd0, 5'd1};
    set_lattice(lims, 1'b0);
    send_random(12);

    lims = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1};
    set_lattice(lims, 1'b0);
    send_random(8);

    lims = '{5'd3, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0, 5'd20, 5'd0};
    set_lattice(lims, 1'b0);
    send_random(25);
    in_valid_i <= 1'b0;
    wait_drained();
    send_random(42);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Checked %0d tuned words over eight lattice settings, %0d with the overflow flag.",
             sb.checked, sb.overflows);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_just_intonation_lattice_quantizer_unit passed");
    end else begin
      $display("tb_just_intonation_lattice_quantizer_unit failed");
    end
    $finish;
  end
endmodule
